// ----- sv/kfce_pkg.sv -----
// Package for the keyframe curve evaluator: sizes, operation codes, status codes,
// the channel payloads and the command and status structs between the controller
// and the datapath. It depends on nothing.
package kfce_pkg;

  localparam int unsigned MaxKeys = 16;
  localparam int unsigned IdxW    = $clog2(MaxKeys);
  localparam int unsigned CntW    = IdxW + 1;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_EVAL   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  localparam logic [1:0] MODE_CONST = 2'd0;

  // One input transfer: a table operation and its operands.
  typedef struct packed {
    func_e              func;
    logic signed [31:0] key_time;
    logic signed [31:0] key_value;
    logic [1:0]         interp_mode;
    logic [3:0]         key_index;
  } key_cmd_t;

  // One output transfer: the curve value, the status and the table size.
  typedef struct packed {
    logic signed [31:0] curve_value;
    status_e            status;
    logic [CntW-1:0]    entry_count;
  } curve_res_t;

  // These are the commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item, set the scan pointer (to idx for a remove, else 0)
    logic scan_step;  // compare one entry and advance the scan pointer
    logic park;       // keep the insert spot and move the pointer to count
    logic shift_step; // move one entry, for insert or remove
    logic write_new;  // write the new key at the scan pointer
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic div_start;
    logic div_step;
    logic mul_step;   // multiply and register the blend
    logic fin_step;   // form the result
  } cmd_t;

  // These are the status flags from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic full;
    logic bad_index;
    logic eval_direct; // the result needs no division
    logic div_done;
  } sts_t;

endpackage

// ----- sv/kfce_if.sv -----
// Valid/ready channel interface that carries one payload of type T_t.
// It depends on nothing.
interface kfce_if #(parameter type T_t = logic) ();
  logic valid;
  logic ready;
  T_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/kfce_ctrl.sv -----
// Controller state machine for the keyframe curve evaluator.
// It depends on kfce_pkg.
module kfce_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     in_func_i,
  output logic           in_ready_o,
  input  logic           out_busy_i,
  output logic           done_o,
  output kfce_pkg::cmd_t cmd_o,
  input  kfce_pkg::sts_t sts_i
);
  import kfce_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_DIV, S_MUL, S_FIN, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [1:0] func_q, func_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    func_d     = func_q;
    in_ready_o = 1'b0;
    done_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          func_d     = in_func_i;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        case (func_e'(func_q))
          FUNC_INSERT: begin
            if (sts_i.full) begin
              state_d = S_DONE;
            end else if (!sts_i.scan_done) begin
              cmd_o.scan_step = 1'b1;
            end else begin
              cmd_o.park = 1'b1;
              state_d    = S_SHIFT;
            end
          end
          FUNC_REMOVE: begin
            state_d = sts_i.bad_index ? S_DONE : S_SHIFT;
          end
          FUNC_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_DONE;
          end
          default: begin
            if (sts_i.eval_direct) begin
              state_d = S_FIN;
            end else if (!sts_i.scan_done) begin
              cmd_o.scan_step = 1'b1;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
        endcase
      end
      S_SHIFT: begin
        if (!sts_i.shift_done) begin
          cmd_o.shift_step = 1'b1;
        end else begin
          if (func_e'(func_q) == FUNC_INSERT) begin
            cmd_o.write_new = 1'b1;
            cmd_o.cnt_inc   = 1'b1;
          end else begin
            cmd_o.cnt_dec = 1'b1;
          end
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_MUL;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin_step = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_busy_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      func_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      func_q  <= func_d;
    end
  end

endmodule

// ----- sv/kfce_dp.sv -----
// Datapath for the keyframe curve evaluator: the key table, the scan pointer,
// the restoring divider and the blend multiplier. It depends on kfce_pkg.
module kfce_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                func_i,
  input  logic signed [31:0]        key_time_i,
  input  logic signed [31:0]        key_value_i,
  input  logic [1:0]                interp_mode_i,
  input  logic [3:0]                key_index_i,
  input  kfce_pkg::cmd_t            cmd_i,
  output kfce_pkg::sts_t            sts_o,
  output logic signed [31:0]        curve_value_o,
  output logic [1:0]                status_o,
  output logic [kfce_pkg::CntW-1:0] entry_count_o
);
  import kfce_pkg::*;

  logic signed [31:0] time_q  [MaxKeys];
  logic signed [31:0] value_q [MaxKeys];
  logic [1:0]         mode_q  [MaxKeys];

  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    ptr_q;      // scan position, then shift position
  logic [1:0]         func_q;
  logic signed [31:0] t_q, v_q;
  logic [1:0]         m_q;
  logic [IdxW-1:0]    idx_q;
  logic [1:0]         status_q;   // decided at load from the table size and the index

  logic [32:0]        rem_q;      // partial remainder
  logic [32:0]        den_q;
  logic [16:0]        quo_q;      // frac, 0 to 65536
  logic [48:0]        num_q;      // dividend, shifted out high first
  logic [5:0]         dcnt_q;
  logic signed [31:0] left_q;
  logic signed [32:0] diff_q;
  logic signed [50:0] prod_q;
  logic               direct_q;   // result is left_q with no blend
  logic signed [31:0] res_q;

  logic [IdxW-1:0] p_idx, pm1_idx, pp1_idx, last_idx;
  assign p_idx    = ptr_q[IdxW-1:0];
  assign pm1_idx  = IdxW'(ptr_q - CntW'(1));
  assign pp1_idx  = IdxW'(ptr_q + CntW'(1));
  assign last_idx = IdxW'(count_q - CntW'(1));

  logic is_eval;
  assign is_eval = (func_e'(func_q) == FUNC_EVAL);

  // An evaluate needs no segment search when the table is empty or the time
  // is clamped to an end value.
  logic eval_empty, eval_first, eval_last;
  assign eval_empty = (count_q == '0);
  assign eval_first = !eval_empty && (count_q == CntW'(1) || t_q <= time_q[0]);
  assign eval_last  = !eval_empty && (t_q >= time_q[last_idx]);

  // The first segment with time[i] <= t <= time[i+1]; clamps rule out t at
  // the ends, so the first i with t <= time[i+1] is the segment.
  logic seg_hit;
  assign seg_hit = (t_q <= time_q[pp1_idx]);

  logic ins_stop;
  assign ins_stop = (ptr_q == count_q) || (time_q[p_idx] > t_q);

  // Insert shifting walks the pointer from count down to the insert spot.
  logic [CntW-1:0] ins_pos_q;

  always_comb begin
    sts_o            = '0;
    sts_o.full       = (count_q == CntW'(MaxKeys));
    sts_o.bad_index  = ({1'b0, idx_q} >= count_q);
    sts_o.eval_direct = eval_empty || eval_first || eval_last;
    sts_o.scan_done  = is_eval ? seg_hit : ins_stop;
    if (func_e'(func_q) == FUNC_INSERT) begin
      sts_o.shift_done = (ptr_q == ins_pos_q);
    end else begin
      sts_o.shift_done = (ptr_q + CntW'(1) >= count_q);
    end
    sts_o.div_done = (dcnt_q == 6'd49);
  end

  logic [32:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_q[31:0], num_q[48]};
  assign rem_sub = rem_sh - den_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      t_q    <= key_time_i;
      v_q    <= key_value_i;
      m_q    <= interp_mode_i;
      idx_q  <= key_index_i;
      if (func_e'(func_i) == FUNC_INSERT && count_q == CntW'(MaxKeys)) begin
        status_q <= ST_FULL;
      end else if (func_e'(func_i) == FUNC_REMOVE && {1'b0, key_index_i} >= count_q) begin
        status_q <= ST_RANGE;
      end else begin
        status_q <= ST_OK;
      end
    end
    if (cmd_i.div_start) begin
      left_q   <= value_q[p_idx];
      diff_q   <= 33'(value_q[pp1_idx]) - 33'(value_q[p_idx]);
      direct_q <= (mode_q[p_idx] == MODE_CONST);
      den_q    <= 33'(time_q[pp1_idx]) - 33'(time_q[p_idx]);
      num_q    <= {33'(t_q) - 33'(time_q[p_idx]), 16'd0};
      rem_q    <= '0;
      quo_q    <= '0;
      dcnt_q   <= '0;
    end
    if (cmd_i.div_step) begin
      if (!rem_sub[32]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[15:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[15:0], 1'b0};
      end
      num_q  <= {num_q[47:0], 1'b0};
      dcnt_q <= dcnt_q + 6'd1;
    end
    if (cmd_i.mul_step) begin
      prod_q <= diff_q * $signed({1'b0, quo_q});
    end
    if (cmd_i.fin_step) begin
      if (!is_eval || eval_empty) begin
        res_q <= '0;
      end else if (eval_first) begin
        res_q <= value_q[0];
      end else if (eval_last) begin
        res_q <= value_q[last_idx];
      end else if (direct_q) begin
        res_q <= left_q;
      end else begin
        res_q <= left_q + 32'(prod_q >>> 16);
      end
    end else if (cmd_i.load) begin
      res_q <= '0;
    end
    if (cmd_i.shift_step) begin
      if (func_e'(func_q) == FUNC_INSERT) begin
        time_q[p_idx]  <= time_q[pm1_idx];
        value_q[p_idx] <= value_q[pm1_idx];
        mode_q[p_idx]  <= mode_q[pm1_idx];
      end else begin
        time_q[p_idx]  <= time_q[pp1_idx];
        value_q[p_idx] <= value_q[pp1_idx];
        mode_q[p_idx]  <= mode_q[pp1_idx];
      end
    end
    if (cmd_i.write_new) begin
      time_q[p_idx]  <= t_q;
      value_q[p_idx] <= v_q;
      mode_q[p_idx]  <= m_q;
    end
  end

  // The pointer scans up for an insert spot or a segment, then for an insert
  // it is parked at count and walks down; for a remove it walks up from idx.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ptr_q     <= '0;
      ins_pos_q <= '0;
    end else begin
      if (cmd_i.load) begin
        ptr_q <= (func_e'(func_i) == FUNC_REMOVE) ? {1'b0, key_index_i} : '0;
      end
      if (cmd_i.scan_step) begin
        ptr_q <= ptr_q + CntW'(1);
      end
      if (cmd_i.park) begin
        ins_pos_q <= ptr_q;
        ptr_q     <= count_q;
      end
      if (cmd_i.shift_step) begin
        ptr_q <= (func_e'(func_q) == FUNC_INSERT) ? ptr_q - CntW'(1) : ptr_q + CntW'(1);
      end
      if (cmd_i.cnt_inc) count_q <= count_q + CntW'(1);
      if (cmd_i.cnt_dec) count_q <= count_q - CntW'(1);
      if (cmd_i.cnt_clr) count_q <= '0;
    end
  end

  assign curve_value_o = res_q;
  assign entry_count_o = count_q;
  assign status_o      = status_q;

endmodule

// ----- sv/keyframe_curve_evaluator_top.sv -----
// Keyframe curve evaluator, top level. One item is handled at a time.
// Insert and remove shift the key table entry by entry; an evaluate that needs a
// segment blend runs the 49-step restoring divider. A new item is taken only when
// the last is done and the controller is back in idle; a held result delays its finish.
// Reset (rst_ni low, asynchronous) empties the table; stored keys stay undefined.
module keyframe_curve_evaluator_top (
  input  logic clk_i,
  input  logic rst_ni,
  kfce_if.sink   in_if,
  kfce_if.source out_if
);
  import kfce_pkg::*;

  kfce_pkg::cmd_t cmd;
  kfce_pkg::sts_t sts;
  logic done;

  logic signed [31:0]  curve_value;
  logic [1:0]          status;
  logic [CntW-1:0]     entry_count;

  // The result register; a finished result waits here while the next item
  // is taken in.
  logic                out_valid_q;
  curve_res_t          out_data_q;

  // The controller accepts an input transfer only while idle, and finishes an
  // item only when the result register is free or being emptied.
  kfce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_func_i  (in_if.data.func),
    .in_ready_o (in_if.ready),
    .out_busy_i (out_valid_q && !out_if.ready),
    .done_o     (done),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // The datapath captures the input item on the load command, so the input
  // payload only has to be stable in the accepting cycle.
  kfce_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (in_if.data.func),
    .key_time_i    (in_if.data.key_time),
    .key_value_i   (in_if.data.key_value),
    .interp_mode_i (in_if.data.interp_mode),
    .key_index_i   (in_if.data.key_index),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .curve_value_o (curve_value),
    .status_o      (status),
    .entry_count_o (entry_count)
  );

  // A new result may be loaded in the same cycle as the old one is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= '{curve_value: curve_value, status: status_e'(status),
                      entry_count: entry_count};
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for keyframe_curve_evaluator_top: random and directed
// keyframe table operations against a built-in predictor of the table and curve.
// Depends on kfce_pkg, kfce_if and the evaluator RTL.
`timescale 1ns / 1ps

module tb_top;
  import kfce_pkg::*;

  localparam int RandItems  = 700;
  localparam int IdleLimit  = 2000;  // longest gap without any transfer
  localparam int LongStall  = 300;   // receiver hold-off, in cycles
  localparam int StallAt    = 300;   // results received before the hold-off
  localparam int DrainAt    = 450;   // items sent before the sender waits out the block
  localparam int BurstLo    = 100;   // items in [BurstLo, BurstHi) go back to back
  localparam int BurstHi    = 180;

  logic clk_i;
  logic rst_ni;

  kfce_if #(.T_t(key_cmd_t))   cmd_if ();
  kfce_if #(.T_t(curve_res_t)) res_if ();

  keyframe_curve_evaluator_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (cmd_if.sink),
    .out_if (res_if.source)
  );

  // Predicted keyframe table.
  logic signed [31:0] key_t_tbl [MaxKeys];
  logic signed [31:0] key_v_tbl [MaxKeys];
  logic [1:0]         key_m_tbl [MaxKeys];
  int                 key_count;

  key_cmd_t   pending_cmds [$];
  curve_res_t expected_res [$];

  int sent_cnt, recv_cnt, err_cnt, idle_cycles;
  int eval_cnt, full_cnt, range_cnt;

  // Curve value at time t for the predicted table.
  function automatic logic signed [31:0] curve_at(logic signed [31:0] t);
    longint t0, t1, den, frac, lv, rv;
    if (key_count == 0) return '0;
    if (key_count == 1 || t <= key_t_tbl[0]) return key_v_tbl[0];
    if (t >= key_t_tbl[key_count-1]) return key_v_tbl[key_count-1];
    for (int i = 0; i + 1 < key_count; i++) begin
      if (t >= key_t_tbl[i] && t <= key_t_tbl[i+1]) begin
        t0  = longint'(key_t_tbl[i]);
        t1  = longint'(key_t_tbl[i+1]);
        den = t1 - t0;
        if (key_m_tbl[i] == MODE_CONST || den <= 0) return key_v_tbl[i];
        frac = ((longint'(t) - t0) * 65536) / den;
        lv   = longint'(key_v_tbl[i]);
        rv   = longint'(key_v_tbl[i+1]);
        // Arithmetic shift floors the product, as the blend requires.
        return 32'(lv + (((rv - lv) * frac) >>> 16));
      end
    end
    return key_v_tbl[key_count-1];
  endfunction

  // Applies one command to the predicted table and returns the result.
  function automatic curve_res_t apply_key_cmd(key_cmd_t c);
    curve_res_t r;
    int pos;
    r = '{curve_value: '0, status: ST_OK, entry_count: '0};
    case (c.func)
      FUNC_INSERT: begin
        if (key_count >= MaxKeys) begin
          r.status = ST_FULL;
          full_cnt++;
        end else begin
          pos = 0;
          while (pos < key_count && key_t_tbl[pos] <= c.key_time) pos++;
          for (int i = key_count; i > pos; i--) begin
            key_t_tbl[i] = key_t_tbl[i-1];
            key_v_tbl[i] = key_v_tbl[i-1];
            key_m_tbl[i] = key_m_tbl[i-1];
          end
          key_t_tbl[pos] = c.key_time;
          key_v_tbl[pos] = c.key_value;
          key_m_tbl[pos] = c.interp_mode;
          key_count++;
        end
      end
      FUNC_REMOVE: begin
        if (int'(c.key_index) >= key_count) begin
          r.status = ST_RANGE;
          range_cnt++;
        end else begin
          for (int i = c.key_index; i + 1 < key_count; i++) begin
            key_t_tbl[i] = key_t_tbl[i+1];
            key_v_tbl[i] = key_v_tbl[i+1];
            key_m_tbl[i] = key_m_tbl[i+1];
          end
          key_count--;
        end
      end
      FUNC_CLEAR: key_count = 0;
      default: begin
        r.curve_value = curve_at(c.key_time);
        eval_cnt++;
      end
    endcase
    r.entry_count = 5'(key_count);
    return r;
  endfunction

  function automatic key_cmd_t mk_cmd(func_e f, logic signed [31:0] t,
                                      logic signed [31:0] v, logic [1:0] m,
                                      logic [3:0] idx);
    key_cmd_t c;
    c.func = f; c.key_time = t; c.key_value = v; c.interp_mode = m; c.key_index = idx;
    return c;
  endfunction

  // Appends one command to the stimulus queue.
  function automatic void add_cmd(key_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Random time: mostly from a small grid so that equal times and narrow
  // segments are common, sometimes anywhere in the full range.
  function automatic logic signed [31:0] rand_time();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 16)) - 8;
      default: return ($signed($urandom_range(0, 16)) - 8) <<< 16;
    endcase
  endfunction

  function automatic key_cmd_t rand_cmd();
    key_cmd_t c;
    int sel;
    sel = $urandom_range(0, 99);
    c.key_time    = rand_time();
    c.key_value   = ($urandom_range(0, 1) != 0) ? $urandom :
                    ($signed($urandom_range(0, 64)) - 32) <<< 14;
    c.interp_mode = 2'($urandom_range(0, 3));
    c.key_index   = 4'($urandom_range(0, 15));
    if (sel < 38)      c.func = FUNC_INSERT;
    else if (sel < 56) c.func = FUNC_REMOVE;
    else if (sel < 59) c.func = FUNC_CLEAR;
    else               c.func = FUNC_EVAL;
    return c;
  endfunction

  // Clock and the single reset pulse.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Stimulus: directed corner cases first, then the random stream.
  initial begin
    key_count = 0;
    // Empty table, then a single keyframe evaluated on both sides of it.
    add_cmd(mk_cmd(FUNC_EVAL,   32'sd5, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_REMOVE, '0, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_INSERT, 32'sh10000, 32'sh30000, 2'd1, 4'd15));
    add_cmd(mk_cmd(FUNC_EVAL,   32'sh80000000, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_EVAL,   32'sh7fffffff, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_CLEAR,  '0, '0, 2'd0, 4'd0));
    // Keys at the extremes of time and value, one per mode, with a duplicate time.
    add_cmd(mk_cmd(FUNC_INSERT, 32'sh7fffffff, 32'sh80000000, 2'd1, 4'd0));
    add_cmd(mk_cmd(FUNC_INSERT, 32'sh80000000, 32'sh7fffffff, 2'd2, 4'd0));
    add_cmd(mk_cmd(FUNC_INSERT, '0, 32'sh12345, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_INSERT, '0, -32'sh54321, 2'd3, 4'd0));
    add_cmd(mk_cmd(FUNC_EVAL,   32'sh80000000, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_EVAL,   32'sh7fffffff, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_EVAL,   '0, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_EVAL,   -32'sh40000001, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_EVAL,   32'sh3fffffff, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_EVAL,   32'sh00000001, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_REMOVE, '0, '0, 2'd0, 4'd15));
    add_cmd(mk_cmd(FUNC_REMOVE, '0, '0, 2'd0, 4'd4));
    add_cmd(mk_cmd(FUNC_REMOVE, '0, '0, 2'd0, 4'd1));
    add_cmd(mk_cmd(FUNC_EVAL,   -32'sd1, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_REMOVE, '0, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_EVAL,   '0, '0, 2'd0, 4'd0));
    add_cmd(mk_cmd(FUNC_CLEAR,  '0, '0, 2'd0, 4'd0));
    for (int i = 0; i < RandItems; i++) add_cmd(rand_cmd());
  end

  // Driver: offers queued commands with a random gap before each one and
  // predicts the result of every accepted transfer.
  int  send_gap;
  logic cmd_fire;
  assign cmd_fire = cmd_if.valid && cmd_if.ready;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      cmd_if.data  <= '0;
      send_gap     <= 0;
      sent_cnt     <= 0;
    end else begin
      if (cmd_fire) begin
        expected_res.insert(expected_res.size(), apply_key_cmd(cmd_if.data));
        sent_cnt <= sent_cnt + 1;
      end
      if (!cmd_if.valid || cmd_fire) begin
        if (send_gap > 0) begin
          cmd_if.valid <= 1'b0;
          send_gap     <= send_gap - 1;
        end else if (pending_cmds.size() > 0 &&
                     !(sent_cnt + int'(cmd_fire) == DrainAt && expected_res.size() > 0)) begin
          // At DrainAt the sender holds back until every result is back.
          cmd_if.data  <= pending_cmds.pop_front();
          cmd_if.valid <= 1'b1;
          send_gap     <= (sent_cnt >= BurstLo && sent_cnt < BurstHi) ? 0 :
                          $urandom_range(0, 10);
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random ready stalls, one long hold-off, and the field checks.
  int recv_gap;
  logic res_fire;
  assign res_fire = res_if.valid && res_if.ready;

  always @(posedge clk_i or negedge rst_ni) begin
    curve_res_t exp_r;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_gap     <= 0;
      recv_cnt     <= 0;
      err_cnt      <= 0;
    end else begin
      if (res_fire) begin
        recv_cnt <= recv_cnt + 1;
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, res_if.data);
          err_cnt <= err_cnt + 1;
        end else begin
          exp_r = expected_res.pop_front();
          if (res_if.data.curve_value !== exp_r.curve_value) begin
            $display("%0t: curve_value expected %0d actual %0d", $time,
                     exp_r.curve_value, res_if.data.curve_value);
            err_cnt <= err_cnt + 1;
          end
          if (res_if.data.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_r.status, res_if.data.status);
            err_cnt <= err_cnt + 1;
          end
          if (res_if.data.entry_count !== exp_r.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     exp_r.entry_count, res_if.data.entry_count);
            err_cnt <= err_cnt + 1;
          end
        end
      end
      // A new wait is drawn after each transfer; ready stays low meanwhile.
      if (res_fire) begin
        res_if.ready <= 1'b0;
        recv_gap     <= (recv_cnt + 1 == StallAt) ? LongStall :
                        (recv_cnt >= BurstLo && recv_cnt < BurstHi) ? 0 :
                        $urandom_range(0, 10);
      end else if (recv_gap > 0) begin
        res_if.ready <= 1'b0;
        recv_gap     <= recv_gap - 1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if (cmd_fire || res_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // End of run: all commands sent, all results back, then a short drain.
  initial begin
    @(posedge rst_ni);
    while (pending_cmds.size() > 0 || cmd_if.valid || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d commands: %0d evaluations, %0d inserts into a full table,",
             sent_cnt, eval_cnt, full_cnt);
    $display("%0d removes out of range, with random stalls on both sides.", range_cnt);
    if (err_cnt == 0 && expected_res.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
